### rtl/lfs_pkg.sv
package lfs_pkg;

  localparam int unsigned AdcW   = 10;
  localparam int unsigned BandW  = 9;
  localparam int unsigned DriveW = 8;
  localparam int unsigned CaseW  = 2;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DataW  = 10;

  localparam logic [AdcW-1:0]   DarkThresholdRst = 10'd512;
  localparam logic [BandW-1:0]  HystBandRst      = 9'd30;
  localparam logic [DriveW-1:0] SlowestBaseRst   = 8'd60;
  localparam logic [DriveW-1:0] FastestBaseRst   = 8'd255;
  localparam logic [DriveW-1:0] SteerGainRst     = 8'd2;
  localparam logic [DriveW-1:0] SearchDriveRst   = 8'd80;

  typedef enum logic [CaseW-1:0] {
    CASE_STOP   = 2'd0,
    CASE_SEARCH = 2'd1,
    CASE_STEER  = 2'd2
  } drive_case_e;

  typedef enum logic [IdxW-1:0] {
    REG_DARK_THRESHOLD  = 3'd0,
    REG_HYSTERESIS_BAND = 3'd1,
    REG_SLOWEST_BASE    = 3'd2,
    REG_FASTEST_BASE    = 3'd3,
    REG_STEER_GAIN      = 3'd4,
    REG_SEARCH_DRIVE    = 3'd5
  } cfg_reg_e;

endpackage

### rtl/lfs_in_if.sv
interface lfs_in_if;
  import lfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [AdcW-1:0]   left_sensor;
  logic [AdcW-1:0]   right_sensor;
  logic [AdcW-1:0]   speed_knob;

  modport source (output valid, output left_sensor, output right_sensor,
                  output speed_knob, input ready);
  modport sink   (input valid, input left_sensor, input right_sensor,
                  input speed_knob, output ready);
endinterface

### rtl/lfs_out_if.sv
interface lfs_out_if;
  import lfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [DriveW-1:0] left_drive;
  logic [DriveW-1:0] right_drive;
  logic [CaseW-1:0]  drive_case;

  modport source (output valid, output left_drive, output right_drive,
                  output drive_case, input ready);
  modport sink   (input valid, input left_drive, input right_drive,
                  input drive_case, output ready);
endinterface

### rtl/lfs_cfg_if.sv
interface lfs_cfg_if;
  import lfs_pkg::*;

  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  index;
  logic [DataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/line_follower_steering.sv
// Line follower steering: each item carries a left and right infrared reading and a speed
// knob reading, and yields one item with left and right motor drive and the drive case
// (stop, search or proportional steering). The block has an input register and a result
// register with all the arithmetic (both products, the division by 1023 and by 100, and
// saturation) done in one combinational pass between them. It takes one item every cycle
// when the output is not stalled; a result waits in the result register until it is taken.
// The on-line hysteresis flags advance as an item leaves the input register.
// Configuration writes are taken every cycle and must only be made while the block is empty.
module line_follower_steering (
  input  logic clk_i,
  input  logic rst_ni,
  lfs_in_if.sink    in_i,
  lfs_out_if.source out_o,
  lfs_cfg_if.sink   cfg_i
);
  import lfs_pkg::*;

  localparam int unsigned GpW      = AdcW + DriveW;
  localparam int unsigned RecipW   = 19;
  localparam int unsigned RecipSh  = 25;
  localparam int unsigned ProdW    = GpW + RecipW;
  localparam int unsigned QW       = 12;
  localparam logic [RecipW-1:0] Recip100 = 19'd335545;
  localparam logic [AdcW:0]     KnobFull = 11'd1023;

  logic [AdcW-1:0]   thr_q;
  logic [BandW-1:0]  band_q;
  logic [DriveW-1:0] slow_q, fast_q, gain_q, search_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= DarkThresholdRst;
      band_q   <= HystBandRst;
      slow_q   <= SlowestBaseRst;
      fast_q   <= FastestBaseRst;
      gain_q   <= SteerGainRst;
      search_q <= SearchDriveRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DARK_THRESHOLD:  thr_q    <= cfg_i.data[AdcW-1:0];
        REG_HYSTERESIS_BAND: band_q   <= cfg_i.data[BandW-1:0];
        REG_SLOWEST_BASE:    slow_q   <= cfg_i.data[DriveW-1:0];
        REG_FASTEST_BASE:    fast_q   <= cfg_i.data[DriveW-1:0];
        REG_STEER_GAIN:      gain_q   <= cfg_i.data[DriveW-1:0];
        REG_SEARCH_DRIVE:    search_q <= cfg_i.data[DriveW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  logic v1_q, v2_q;
  logic en1, en2;

  assign en2 = !v2_q || out_o.ready;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  logic [AdcW-1:0] left1_q, right1_q, knob1_q;
  logic            left_seen_q, right_seen_q;
  logic            left_seen_d, right_seen_d;

  function automatic logic seen_next(input logic [AdcW-1:0] rd, input logic was_on,
                                     input logic [AdcW-1:0] thr, input logic [BandW-1:0] band);
    logic [AdcW:0] rd_w, thr_w, band_w;
    rd_w   = {1'b0, rd};
    thr_w  = {1'b0, thr};
    band_w = {2'b00, band};
    if (was_on) begin
      return (rd_w + band_w) > thr_w;
    end
    return rd_w > (thr_w + band_w);
  endfunction

  assign left_seen_d  = seen_next(left1_q, left_seen_q, thr_q, band_q);
  assign right_seen_d = seen_next(right1_q, right_seen_q, thr_q, band_q);

  drive_case_e       case_d;
  logic [AdcW:0]     sdiff;
  logic              dneg_d;
  logic [AdcW-1:0]   absd;
  logic              spneg_d;
  logic [DriveW-1:0] abspan;
  logic [GpW-1:0]    gp_d, kp_d;

  always_comb begin
    if (left_seen_d && right_seen_d) begin
      case_d = CASE_STOP;
    end else if (!left_seen_d && !right_seen_d) begin
      case_d = CASE_SEARCH;
    end else begin
      case_d = CASE_STEER;
    end
    sdiff   = {1'b0, right1_q} - {1'b0, left1_q};
    dneg_d  = sdiff[AdcW];
    absd    = dneg_d ? AdcW'(-sdiff) : sdiff[AdcW-1:0];
    spneg_d = fast_q < slow_q;
    abspan  = spneg_d ? (slow_q - fast_q) : (fast_q - slow_q);
    gp_d    = GpW'(absd) * GpW'(gain_q);
    kp_d    = GpW'(knob1_q) * GpW'(abspan);
  end

  logic [DriveW-1:0] q0, kq;
  logic [AdcW:0]     rem;
  logic signed [AdcW-1:0] base;
  logic [ProdW-1:0]  prod100;
  logic [QW-1:0]     q100;
  logic signed [QW:0]   corr;
  logic signed [QW+1:0] lsum, rsum;
  drive_case_e       case3_d;
  logic [DriveW-1:0] ldrive_d, rdrive_d;

  function automatic logic [DriveW-1:0] sat8(input logic signed [QW+1:0] v);
    if (v < 0) begin
      return '0;
    end
    if (v > $signed((QW+2)'(255))) begin
      return '1;
    end
    return v[DriveW-1:0];
  endfunction

  always_comb begin
    q0   = kp_d[GpW-1:AdcW];
    rem  = {1'b0, kp_d[AdcW-1:0]} + (AdcW+1)'(q0);
    kq   = (rem >= KnobFull) ? q0 + 8'd1 : q0;
    base = spneg_d ? $signed({2'b00, slow_q}) - $signed({2'b00, kq})
                   : $signed({2'b00, slow_q}) + $signed({2'b00, kq});
    prod100 = ProdW'(gp_d) * ProdW'(Recip100);
    q100    = prod100[RecipSh+QW-1:RecipSh];
    corr    = dneg_d ? -$signed({1'b0, q100}) : $signed({1'b0, q100});
    lsum    = (QW+2)'(base) + (QW+2)'(corr);
    rsum    = (QW+2)'(base) - (QW+2)'(corr);
    case3_d = case_d;
    case (case_d)
      CASE_STOP: begin
        ldrive_d = '0;
        rdrive_d = '0;
      end
      CASE_SEARCH: begin
        ldrive_d = search_q;
        rdrive_d = search_q;
      end
      CASE_STEER: begin
        ldrive_d = sat8(lsum);
        rdrive_d = sat8(rsum);
      end
      default: begin
        ldrive_d = '0;
        rdrive_d = '0;
      end
    endcase
  end

  drive_case_e       case3_q;
  logic [DriveW-1:0] ldrive_q, rdrive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      left_seen_q  <= 1'b0;
      right_seen_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
        if (v1_q) begin
          left_seen_q  <= left_seen_d;
          right_seen_q <= right_seen_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      left1_q  <= in_i.left_sensor;
      right1_q <= in_i.right_sensor;
      knob1_q  <= in_i.speed_knob;
    end
    if (en2 && v1_q) begin
      case3_q  <= case3_d;
      ldrive_q <= ldrive_d;
      rdrive_q <= rdrive_d;
    end
  end

  assign out_o.valid       = v2_q;
  assign out_o.left_drive  = ldrive_q;
  assign out_o.right_drive = rdrive_q;
  assign out_o.drive_case  = case3_q;

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (case3_q == CASE_STOP) |-> (ldrive_q == '0) && (rdrive_q == '0))
    else $error("stop item carries nonzero drive");

  a_search_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (case3_q == CASE_SEARCH) |-> (ldrive_q == rdrive_q))
    else $error("search item drives differ");

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_i.ready)
    else $error("empty input stage refuses an item");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en2 && v1_q |=> v2_q)
    else $error("item lost between input and result stage");

endmodule
